### rtl/core/gmht_pkg.sv
package gmht_pkg;

   // Field widths fixed by the item format.
   localparam int CODE_POINT_W = 21;
   localparam int METRIC_W     = 16;

   // Default table geometry.
   localparam int DEF_BUCKETS = 8;
   localparam int DEF_ENTRIES = 128;

   // The bucket number is formed by a reciprocal multiplication that gives
   // the quotient, then a subtract that leaves the remainder.
   localparam int MOD_STEPS = 2;

   // Code points with special meaning on a lookup.
   localparam logic [CODE_POINT_W-1:0] CP_TAB     = CODE_POINT_W'(9);
   localparam logic [CODE_POINT_W-1:0] CP_NEWLINE = CODE_POINT_W'(10);
   localparam logic [CODE_POINT_W-1:0] CP_SPACE   = CODE_POINT_W'(32);

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       mod_step;
      logic       head_rd;
      logic       entry_rd;
      logic       commit;
      logic       res_load;
      logic       res_data;
      status_type res_status;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic newline;
      logic mod_last;
      logic is_insert;
      logic more;
      logic key_match;
      logic pool_full;
   } ctrl_sts_type;

endpackage

### rtl/core/gmht_ctrl.sv
module gmht_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   input  gmht_pkg::ctrl_sts_type sts,
   output gmht_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD,
      S_HEAD,
      S_FETCH,
      S_CHECK
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.res_status = gmht_pkg::ST_OK;
      state_in       = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (sts.newline) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = gmht_pkg::ST_NOT_FOUND;
               state_in       = S_IDLE;
            end else begin
               cmd.mod_step = 1'b1;
               if (sts.mod_last) begin
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in    = S_FETCH;
         end
         S_FETCH: begin
            if (sts.more) begin
               cmd.entry_rd = 1'b1;
               state_in     = S_CHECK;
            end else begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
               if (!sts.is_insert) begin
                  cmd.res_status = gmht_pkg::ST_NOT_FOUND;
               end else if (sts.pool_full) begin
                  cmd.res_status = gmht_pkg::ST_FULL;
               end else begin
                  cmd.commit     = 1'b1;
                  cmd.res_status = gmht_pkg::ST_OK;
               end
            end
         end
         S_CHECK: begin
            if (sts.key_match) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
               if (sts.is_insert) begin
                  cmd.res_status = gmht_pkg::ST_DUPLICATE;
               end else begin
                  cmd.res_status = gmht_pkg::ST_OK;
                  cmd.res_data   = 1'b1;
               end
            end else begin
               state_in = S_FETCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (state_in != S_IDLE);
         rsp_valid_ff <= cmd.res_load;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   // A result strobe lasts one cycle and leaves the block ready.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff ##1 !rsp_valid_ff)
      else $error("result strobe longer than one cycle or block still busy");

   // An accepted item makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("accepted item did not make the block busy");

   // A new entry is never written into a full pool.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !sts.pool_full)
      else $error("commit while the pool is full");

   // An entry is fetched only while the chain continues.
   assert property (@(posedge clock) disable iff (reset)
      cmd.entry_rd |-> sts.more)
      else $error("entry fetch past the end of a chain");

endmodule

### rtl/core/gmht_dp.sv
module gmht_dp #(
   parameter int BUCKETS = gmht_pkg::DEF_BUCKETS,
   parameter int ENTRIES = gmht_pkg::DEF_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gmht_pkg::ctrl_cmd_type              cmd,
   output gmht_pkg::ctrl_sts_type              sts,
   input  logic                                req_cmd,
   input  logic [gmht_pkg::CODE_POINT_W-1:0]   req_code_point,
   input  logic signed [gmht_pkg::METRIC_W-1:0] req_bearing_x_in,
   input  logic signed [gmht_pkg::METRIC_W-1:0] req_bearing_y_in,
   input  logic [gmht_pkg::METRIC_W-1:0]       req_glyph_width_in,
   input  logic [gmht_pkg::METRIC_W-1:0]       req_glyph_height_in,
   input  logic signed [gmht_pkg::METRIC_W-1:0] req_advance_x_in,
   input  logic signed [gmht_pkg::METRIC_W-1:0] req_advance_y_in,
   input  logic [gmht_pkg::METRIC_W-1:0]       req_texture_handle_in,
   output logic [1:0]                          rsp_status,
   output logic signed [gmht_pkg::METRIC_W-1:0] rsp_bearing_x_out,
   output logic signed [gmht_pkg::METRIC_W-1:0] rsp_bearing_y_out,
   output logic [gmht_pkg::METRIC_W-1:0]       rsp_glyph_width_out,
   output logic [gmht_pkg::METRIC_W-1:0]       rsp_glyph_height_out,
   output logic signed [gmht_pkg::METRIC_W-1:0] rsp_advance_x_out,
   output logic signed [gmht_pkg::METRIC_W-1:0] rsp_advance_y_out,
   output logic [gmht_pkg::METRIC_W-1:0]       rsp_texture_handle_out
);

   localparam int KW   = gmht_pkg::CODE_POINT_W;
   localparam int MTW  = gmht_pkg::METRIC_W;
   localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int EW   = $clog2(ENTRIES);
   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int SCW  = $clog2(gmht_pkg::MOD_STEPS);

   // The quotient is floor(key * RECIP / 2^RSH), exact for every key of
   // KW bits since RECIP rounds 2^RSH / BUCKETS upwards.
   localparam int     RSH     = KW + $clog2(BUCKETS);
   localparam int     PW      = 2 * KW + 1;
   localparam int     QW      = PW - RSH;
   localparam longint RECIP   = ((longint'(1) << RSH) + longint'(BUCKETS) - 1) /
                                longint'(BUCKETS);
   localparam logic [KW:0] RECIP_C = (KW+1)'(RECIP);

   // Item registers.
   logic                 is_insert_ff;
   logic                 newline_ff;
   logic [KW-1:0]        key_ff;
   logic [4*MTW-1:0]     metric_ff;
   logic [3*MTW-1:0]     advtex_ff;

   // Bucket remainder unit.
   logic [BW-1:0]        rem_ff, rem_in;
   logic [SCW-1:0]       step_ff;
   logic [PW-1:0]        prod;
   logic [QW-1:0]        quot_ff;
   logic [KW-1:0]        quot_b;
   logic [KW-1:0]        rem_wide;

   // Table state.
   logic [EW-1:0]        head_mem [BUCKETS];
   logic [BUCKETS-1:0]   head_valid_ff;
   logic [CW-1:0]        count_ff;
   logic [KW-1:0]        key_mem [ENTRIES];
   logic [EW:0]          link_mem [ENTRIES];
   logic [4*MTW-1:0]     metric_mem [ENTRIES];
   logic [3*MTW-1:0]     advtex_mem [ENTRIES];

   // Read data and walk state.
   logic [EW-1:0]        head_q_ff;
   logic                 head_vld_q_ff;
   logic                 sel_head_ff;
   logic [KW-1:0]        key_q_ff;
   logic [EW:0]          link_q_ff;
   logic [4*MTW-1:0]     metric_q_ff;
   logic [3*MTW-1:0]     advtex_q_ff;
   logic [EW-1:0]        ptr;
   logic [EW-1:0]        wr_addr;
   logic [KW-1:0]        key_eff;

   assign key_eff = (!req_cmd && req_code_point == gmht_pkg::CP_TAB) ?
                    gmht_pkg::CP_SPACE : req_code_point;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_insert_ff <= req_cmd;
         newline_ff   <= !req_cmd && (req_code_point == gmht_pkg::CP_NEWLINE);
         key_ff       <= key_eff;
         metric_ff    <= {req_glyph_height_in, req_glyph_width_in,
                          req_bearing_y_in, req_bearing_x_in};
         advtex_ff    <= {req_texture_handle_in, req_advance_y_in, req_advance_x_in};
      end
   end

   // The first step registers the quotient; the second subtracts the
   // quotient times BUCKETS from the key to leave the bucket number.
   always_comb begin
      prod     = PW'(key_ff) * PW'(RECIP_C);
      quot_b   = KW'(quot_ff) * KW'(BUCKETS);
      rem_wide = key_ff - quot_b;
      rem_in   = rem_wide[BW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff   <= '0;
         step_ff  <= '0;
      end else if (cmd.mod_step) begin
         quot_ff  <= prod[PW-1:RSH];
         rem_ff   <= rem_in;
         step_ff  <= step_ff + SCW'(1);
      end
   end

   assign ptr     = sel_head_ff ? head_q_ff : link_q_ff[EW-1:0];
   assign wr_addr = count_ff[EW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         head_mem[rem_ff] <= wr_addr;
      end
      if (cmd.head_rd) begin
         head_q_ff <= head_mem[rem_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= '0;
         count_ff      <= '0;
      end else if (cmd.commit) begin
         head_valid_ff[rem_ff] <= 1'b1;
         count_ff              <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.head_rd) begin
         head_vld_q_ff <= head_valid_ff[rem_ff];
         sel_head_ff   <= 1'b1;
      end else if (cmd.entry_rd) begin
         sel_head_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         key_mem[wr_addr]    <= key_ff;
         link_mem[wr_addr]   <= {head_vld_q_ff, head_q_ff};
         metric_mem[wr_addr] <= metric_ff;
         advtex_mem[wr_addr] <= advtex_ff;
      end
      if (cmd.entry_rd) begin
         key_q_ff    <= key_mem[ptr];
         link_q_ff   <= link_mem[ptr];
         metric_q_ff <= metric_mem[ptr];
         advtex_q_ff <= advtex_mem[ptr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         rsp_status <= cmd.res_status;
         if (cmd.res_data) begin
            rsp_bearing_x_out      <= metric_q_ff[MTW-1:0];
            rsp_bearing_y_out      <= metric_q_ff[2*MTW-1:MTW];
            rsp_glyph_width_out    <= metric_q_ff[3*MTW-1:2*MTW];
            rsp_glyph_height_out   <= metric_q_ff[4*MTW-1:3*MTW];
            rsp_advance_x_out      <= advtex_q_ff[MTW-1:0];
            rsp_advance_y_out      <= advtex_q_ff[2*MTW-1:MTW];
            rsp_texture_handle_out <= advtex_q_ff[3*MTW-1:2*MTW];
         end else begin
            rsp_bearing_x_out      <= '0;
            rsp_bearing_y_out      <= '0;
            rsp_glyph_width_out    <= '0;
            rsp_glyph_height_out   <= '0;
            rsp_advance_x_out      <= '0;
            rsp_advance_y_out      <= '0;
            rsp_texture_handle_out <= '0;
         end
      end
   end

   always_comb begin
      sts.newline   = newline_ff;
      sts.mod_last  = (step_ff == SCW'(gmht_pkg::MOD_STEPS - 1));
      sts.is_insert = is_insert_ff;
      sts.more      = sel_head_ff ? head_vld_q_ff : link_q_ff[EW];
      sts.key_match = (key_q_ff == key_ff);
      sts.pool_full = (count_ff == CW'(ENTRIES));
   end

endmodule

### rtl/core/glyph_metrics_hash_table.sv
// Glyph metrics store keyed by Unicode code point, kept as a chained hash
// table. An item is accepted at a rising edge with start high and busy low;
// busy then stays high until the result item has been produced, and exactly
// one result item follows every accepted item. The result appears on the
// rsp_ ports for one cycle only, marked by rsp_valid, and cannot be held
// off, so the receiver must capture it in that cycle; the ports keep their
// values until the next result. The bucket number is formed first (code
// point modulo BUCKETS, a reciprocal multiplication and then a subtract),
// then the bucket head is read, and every chain entry visited costs a read
// of the entry memory plus a key compare. The walk ends at the end of its
// chain (lookup miss, insert, full pool) or at a matching entry (lookup
// hit, duplicate key). A lookup of newline is answered as not found without
// a table walk. A new item may be started in the cycle of the strobe.
// Entries are never freed; once ENTRIES glyphs are stored, inserts report
// a full pool. No clearing pass is needed after reset.
module glyph_metrics_hash_table #(
   parameter int BUCKETS = gmht_pkg::DEF_BUCKETS,
   parameter int ENTRIES = gmht_pkg::DEF_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_cmd,
   input  logic [gmht_pkg::CODE_POINT_W-1:0]   req_code_point,
   input  logic signed [gmht_pkg::METRIC_W-1:0] req_bearing_x_in,
   input  logic signed [gmht_pkg::METRIC_W-1:0] req_bearing_y_in,
   input  logic [gmht_pkg::METRIC_W-1:0]       req_glyph_width_in,
   input  logic [gmht_pkg::METRIC_W-1:0]       req_glyph_height_in,
   input  logic signed [gmht_pkg::METRIC_W-1:0] req_advance_x_in,
   input  logic signed [gmht_pkg::METRIC_W-1:0] req_advance_y_in,
   input  logic [gmht_pkg::METRIC_W-1:0]       req_texture_handle_in,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic signed [gmht_pkg::METRIC_W-1:0] rsp_bearing_x_out,
   output logic signed [gmht_pkg::METRIC_W-1:0] rsp_bearing_y_out,
   output logic [gmht_pkg::METRIC_W-1:0]       rsp_glyph_width_out,
   output logic [gmht_pkg::METRIC_W-1:0]       rsp_glyph_height_out,
   output logic signed [gmht_pkg::METRIC_W-1:0] rsp_advance_x_out,
   output logic signed [gmht_pkg::METRIC_W-1:0] rsp_advance_y_out,
   output logic [gmht_pkg::METRIC_W-1:0]       rsp_texture_handle_out
);

   // The controller sequences each item; the datapath holds the tables,
   // the remainder unit and the result registers.
   gmht_pkg::ctrl_cmd_type cmd;
   gmht_pkg::ctrl_sts_type sts;

   gmht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   gmht_dp #(
      .BUCKETS (BUCKETS),
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_cmd                (req_cmd),
      .req_code_point         (req_code_point),
      .req_bearing_x_in       (req_bearing_x_in),
      .req_bearing_y_in       (req_bearing_y_in),
      .req_glyph_width_in     (req_glyph_width_in),
      .req_glyph_height_in    (req_glyph_height_in),
      .req_advance_x_in       (req_advance_x_in),
      .req_advance_y_in       (req_advance_y_in),
      .req_texture_handle_in  (req_texture_handle_in),
      .rsp_status             (rsp_status),
      .rsp_bearing_x_out      (rsp_bearing_x_out),
      .rsp_bearing_y_out      (rsp_bearing_y_out),
      .rsp_glyph_width_out    (rsp_glyph_width_out),
      .rsp_glyph_height_out   (rsp_glyph_height_out),
      .rsp_advance_x_out      (rsp_advance_x_out),
      .rsp_advance_y_out      (rsp_advance_y_out),
      .rsp_texture_handle_out (rsp_texture_handle_out)
   );

endmodule
